// ===== sv/lpcrc8_pkg.sv =====
// package: word types, buffer depth and crc-8 update for the frame receiver
package lpcrc8_pkg;

  localparam int BufDepth = 16;
  localparam int IdxW     = (BufDepth > 1) ? $clog2(BufDepth) : 1;
  localparam logic [7:0] CrcPoly = 8'h8C;

  typedef enum logic [1:0] {
    ACT_BYTE    = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_READ    = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic [3:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic [7:0] pending_length;
    logic       frame_done;
    logic       byte_ignored;
    logic       overflow;
    logic [7:0] read_data;
  } out_word_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/length_prefixed_crc8_frame_receiver.sv =====
// top level: length-prefixed frame receiver with crc-8 check and output skid stage
//
// in channel: in_valid_i / in_stall_o / in_word_i carries one command word:
//   a received serial byte, a release of the pending frame, or a read of a
//   stored payload byte by index.
// out channel: out_valid_o / out_stall_i / out_word_o returns one result word
//   per command word: pending length, frame done, byte ignored, overflow and
//   read data.
// a word is taken whenever valid is high and stall is low.
// the result of a taken word is registered in out_q, or first in the skid
//   register while the output stalls. throughput: one word per cycle while
//   in_stall_o is low; the crc update is combinational; output stalls limit it.
// when the output is stalled, one more result is held in a skid register and
//   in_stall_o rises until that register drains.
// reset clears the frame state, the pending length and both output valid flags;
//   payload buffer contents are undefined until written by a frame.
module length_prefixed_crc8_frame_receiver (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  lpcrc8_pkg::in_word_t  in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output lpcrc8_pkg::out_word_t out_word_o
);
  import lpcrc8_pkg::*;

  logic      in_accept;
  out_word_t result;
  logic      out_valid_q;
  out_word_t out_q;
  logic      skid_valid_q;
  out_word_t skid_q;
  logic      out_free;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  lpcrc8_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .word_i   (in_word_i),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_accept) begin
        out_q <= result;
      end
    end else if (in_accept) begin
      skid_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== sv/lpcrc8_core.sv =====
// frame state, crc check, payload buffer and per-word result logic
module lpcrc8_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  lpcrc8_pkg::in_word_t  word_i,
  output lpcrc8_pkg::out_word_t result_o
);
  import lpcrc8_pkg::*;

  logic [7:0] exp_len_q, exp_len_d;
  logic [7:0] pos_q, pos_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] pend_q, pend_d;
  logic [7:0] store_q [BufDepth];

  logic       wr_en;
  logic [7:0] crc_next;
  logic       pos_in_buf;
  logic [7:0] rd_idx;
  logic       rd_in_buf;
  action_e    act;

  assign act        = action_e'(word_i.action);
  assign crc_next   = crc8_update(crc_q, word_i.rx_byte);
  assign pos_in_buf = pos_q < 8'(BufDepth);
  assign rd_idx     = 8'(word_i.read_index);
  assign rd_in_buf  = rd_idx < 8'(BufDepth);

  always_comb begin
    exp_len_d = exp_len_q;
    pos_d     = pos_q;
    crc_d     = crc_q;
    pend_d    = pend_q;
    wr_en     = 1'b0;
    result_o  = '0;
    case (act)
      ACT_BYTE: begin
        if (pend_q != 8'd0) begin
          result_o.byte_ignored = 1'b1;
        end else if (exp_len_q == 8'd0) begin
          if (word_i.rx_byte != 8'd0) begin
            exp_len_d = word_i.rx_byte;
            pos_d     = 8'd0;
            crc_d     = crc8_update(8'd0, word_i.rx_byte);
          end
        end else if (pos_q < exp_len_q) begin
          if (pos_in_buf) begin
            wr_en = 1'b1;
          end else begin
            result_o.overflow = 1'b1;
          end
          crc_d = crc_next;
          pos_d = pos_q + 8'd1;
        end else if (crc_q == word_i.rx_byte) begin
          pend_d              = exp_len_q;
          exp_len_d           = 8'd0;
          result_o.frame_done = 1'b1;
        end
      end
      ACT_RELEASE: pend_d = 8'd0;
      ACT_READ: begin
        if (rd_in_buf) begin
          result_o.read_data = store_q[rd_idx[IdxW-1:0]];
        end
      end
      default: ;
    endcase
    result_o.pending_length = pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= '0;
      pos_q     <= '0;
      crc_q     <= '0;
      pend_q    <= '0;
    end else if (accept_i) begin
      exp_len_q <= exp_len_d;
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && wr_en) begin
      store_q[pos_q[IdxW-1:0]] <= word_i.rx_byte;
    end
  end

endmodule

// ===== sv/lpcrc8_checker.sv =====
// port checker for the frame receiver, bound to the top level
module lpcrc8_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input lpcrc8_pkg::in_word_t  in_word_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input lpcrc8_pkg::out_word_t out_word_o
);
  import lpcrc8_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  a_done_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.frame_done |-> out_word_o.pending_length != 8'd0)
    else $error("frame done without pending length");

  a_ignored_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.byte_ignored |-> out_word_o.pending_length != 8'd0)
    else $error("byte ignored with no frame pending");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.overflow && (out_word_o.frame_done ||
                      out_word_o.byte_ignored)) &&
                    !(out_word_o.frame_done && out_word_o.byte_ignored))
    else $error("conflicting result flags");

endmodule

bind length_prefixed_crc8_frame_receiver lpcrc8_checker u_lpcrc8_checker (.*);
